FILE: hdl/ssbi_pkg.sv
package ssbi_pkg;

  localparam int unsigned Rounds = 64;
  localparam logic [31:0] SaltWord = 32'h61736466;
  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] MsgBits = 32'd64;
  localparam logic [31:0] TableEntriesReset = 32'd1;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } hstate_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
    word_t w4;
    word_t w5;
    word_t w6;
    word_t w7;
    word_t w8;
    word_t w9;
    word_t w10;
    word_t w11;
    word_t w12;
    word_t w13;
    word_t w14;
    word_t w15;
  } sched_t;

  localparam hstate_t InitH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t swap32(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

FILE: hdl/ssbi_round_cell.sv
module ssbi_round_cell #(
  parameter logic [5:0] ROUND = 6'd0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  ssbi_pkg::hstate_t st_in,
  input  ssbi_pkg::sched_t  w_in,
  output logic            valid_out,
  output ssbi_pkg::hstate_t st_out,
  output ssbi_pkg::sched_t  w_out
);

  ssbi_pkg::word_t s0, s1, w_new, ch, maj, t1, t2, ss0, ss1;
  ssbi_pkg::hstate_t st_next;
  ssbi_pkg::sched_t  w_next;

  always_comb begin
    s0 = {w_in.w1[6:0], w_in.w1[31:7]} ^ {w_in.w1[17:0], w_in.w1[31:18]} ^ (w_in.w1 >> 3);
    s1 = {w_in.w14[16:0], w_in.w14[31:17]} ^ {w_in.w14[18:0], w_in.w14[31:19]}
         ^ (w_in.w14 >> 10);
    w_new = w_in.w0 + s0 + w_in.w9 + s1;
    w_next = {w_in.w1, w_in.w2, w_in.w3, w_in.w4, w_in.w5, w_in.w6, w_in.w7, w_in.w8,
              w_in.w9, w_in.w10, w_in.w11, w_in.w12, w_in.w13, w_in.w14, w_in.w15, w_new};
    ss1 = {st_in.e[5:0], st_in.e[31:6]} ^ {st_in.e[10:0], st_in.e[31:11]}
          ^ {st_in.e[24:0], st_in.e[31:25]};
    ch = (st_in.e & st_in.f) ^ (~st_in.e & st_in.g);
    t1 = st_in.h + ss1 + ch + ssbi_pkg::round_k(ROUND) + w_in.w0;
    ss0 = {st_in.a[1:0], st_in.a[31:2]} ^ {st_in.a[12:0], st_in.a[31:13]}
          ^ {st_in.a[21:0], st_in.a[31:22]};
    maj = (st_in.a & st_in.b) ^ (st_in.a & st_in.c) ^ (st_in.b & st_in.c);
    t2 = ss0 + maj;
    st_next = '{t1 + t2, st_in.a, st_in.b, st_in.c, st_in.d + t1, st_in.e, st_in.f, st_in.g};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      st_out <= st_next;
      w_out <= w_next;
    end
  end

endmodule

FILE: hdl/ssbi_mod_cell.sv
module ssbi_mod_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        valid_in,
  input  logic [63:0] num_in,
  input  logic [32:0] rem_in,
  input  logic [31:0] div_in,
  output logic        valid_out,
  output logic [63:0] num_out,
  output logic [32:0] rem_out,
  output logic [31:0] div_out
);

  logic [33:0] trial;
  logic [32:0] rem_next;

  always_comb begin
    trial = {rem_in, num_in[BIT]} - {2'b00, div_in};
    if (trial[33]) begin
      rem_next = {rem_in[31:0], num_in[BIT]};
    end else begin
      rem_next = trial[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      num_out <= num_in;
      rem_out <= rem_next;
      div_out <= div_in;
    end
  end

endmodule

FILE: hdl/salted_sha256_bucket_index_unit.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid / in_ready       | ip_address
// out     | output    | out_valid / out_ready     | bucket_index
// cfg     | input     | cfg_we                    | cfg_wdata (table_entries)
// One word is accepted per cycle unless the chain holds; each passes 64 compression
// cells, one digest add stage and 64 restoring remainder cells, all registered.
// The whole chain advances together and holds when the output register is full and
// not taken. Reset is synchronous and clears valid bits; table_entries returns to 1.
// A zero table size gives index 0.
module salted_sha256_bucket_index_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] ip_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] bucket_index,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned R = ssbi_pkg::Rounds;

  logic [31:0] table_entries;
  logic en;

  logic              rv [R+1];
  ssbi_pkg::hstate_t rs [R+1];
  ssbi_pkg::sched_t  rw [R+1];

  logic        mv [65];
  logic [63:0] mn [65];
  logic [32:0] mr [65];
  logic [31:0] md [65];

  logic [63:0] digest_next;
  logic        digest_valid;
  logic [63:0] digest;
  logic [31:0] digest_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_entries <= ssbi_pkg::TableEntriesReset;
    end else if (cfg_we) begin
      table_entries <= cfg_wdata;
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  assign rv[0] = in_valid;
  assign rs[0] = ssbi_pkg::InitH;
  assign rw[0] = '{ssbi_pkg::swap32(ip_address), ssbi_pkg::SaltWord, ssbi_pkg::PadWord,
                   32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                   32'd0, 32'd0, 32'd0, ssbi_pkg::MsgBits};

  for (genvar i = 0; i < R; i++) begin : g_round
    ssbi_round_cell #(.ROUND(6'(i))) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(rv[i]), .st_in(rs[i]), .w_in(rw[i]),
      .valid_out(rv[i+1]), .st_out(rs[i+1]), .w_out(rw[i+1])
    );
  end

  assign digest_next = {ssbi_pkg::swap32(ssbi_pkg::InitH.b + rs[R].b),
                        ssbi_pkg::swap32(ssbi_pkg::InitH.a + rs[R].a)};

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (en) begin
      digest_valid <= rv[R];
    end
    if (en) begin
      digest <= digest_next;
      digest_div <= table_entries;
    end
  end

  assign mv[0] = digest_valid;
  assign mn[0] = digest;
  assign mr[0] = '0;
  assign md[0] = digest_div;

  for (genvar j = 0; j < 64; j++) begin : g_mod
    ssbi_mod_cell #(.BIT(63 - j)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(mv[j]), .num_in(mn[j]), .rem_in(mr[j]), .div_in(md[j]),
      .valid_out(mv[j+1]), .num_out(mn[j+1]), .rem_out(mr[j+1]), .div_out(md[j+1])
    );
  end

  assign out_valid = mv[64];
  assign bucket_index = (md[64] == 32'd0) ? 32'd0 : mr[64][31:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bucket_index))
    else $error("result changed while stalled");
  a_below: assert property (@(posedge clk) disable iff (rst)
    out_valid && md[64] != 32'd0 |-> bucket_index < md[64])
    else $error("index not below table size");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(digest_valid) && $stable(rv[1]))
    else $error("chain moved during stall");

endmodule
